/* src/triangle_tangent_frame_unit_defines.svh */
// Assertion macros shared by the tangent frame unit RTL.
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TTF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tangent frame unit assertion failed");
`define TTF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tangent frame unit assertion failed");
`else
`define TTF_ASSERT_IMP(label, ante, cons)
`define TTF_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/ttf_pkg.sv */
// Shared types and constants of the tangent frame unit.
package ttf_pkg;

    localparam int POS_W     = 24;
    localparam int TEX_W     = 16;
    localparam int EDGE_W    = POS_W + 1;
    localparam int DUV_W     = TEX_W + 1;
    localparam int OUT_W     = 16;
    localparam int OPA_W     = 31;
    localparam int PROD_W    = 2 * OPA_W;
    localparam int ACC_W     = 43;
    localparam int NORM_BITS = 30;
    localparam int LEN_W     = 31;
    localparam int Q_W       = 15;
    localparam int FRAC_BITS = 14;
    localparam int REM_W     = NORM_BITS + FRAC_BITS + 1;
    localparam int SQ_W      = 62;
    localparam int BIT_W     = 61;
    localparam int UNIT_Q14  = 16384;
    localparam int NUM_PRODUCTS = 14;
    localparam int NUM_TERMS    = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } t_corner;

    typedef struct packed {
        logic signed [EDGE_W-1:0] e1x;
        logic signed [EDGE_W-1:0] e1y;
        logic signed [EDGE_W-1:0] e1z;
        logic signed [EDGE_W-1:0] e2x;
        logic signed [EDGE_W-1:0] e2y;
        logic signed [EDGE_W-1:0] e2z;
        logic signed [DUV_W-1:0]  du1;
        logic signed [DUV_W-1:0]  dv1;
        logic signed [DUV_W-1:0]  du2;
        logic signed [DUV_W-1:0]  dv2;
    } t_tri;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] bitangent_x;
        logic signed [OUT_W-1:0] bitangent_y;
        logic signed [OUT_W-1:0] bitangent_z;
        logic                    degenerate;
    } t_result;

endpackage

/* src/ttf_front.sv */
// Front part: collects corners and forms edges and UV deltas per triangle.
module ttf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  ttf_pkg::t_corner                    i_corner,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output ttf_pkg::t_tri                       o_tri
);

    logic [1:0]       r_count;
    ttf_pkg::t_corner r_c0;
    ttf_pkg::t_corner r_c1;
    logic             w_accept;

    // Only the closing corner of a triangle needs room in the queue.
    assign full     = i_q_full && (r_count == 2'd2);
    assign w_accept = push && !full;
    assign o_q_push = w_accept && (r_count == 2'd2);

    always_comb begin
        o_tri.e1x = ttf_pkg::EDGE_W'(r_c1.pos_x) - ttf_pkg::EDGE_W'(r_c0.pos_x);
        o_tri.e1y = ttf_pkg::EDGE_W'(r_c1.pos_y) - ttf_pkg::EDGE_W'(r_c0.pos_y);
        o_tri.e1z = ttf_pkg::EDGE_W'(r_c1.pos_z) - ttf_pkg::EDGE_W'(r_c0.pos_z);
        o_tri.e2x = ttf_pkg::EDGE_W'(i_corner.pos_x) - ttf_pkg::EDGE_W'(r_c0.pos_x);
        o_tri.e2y = ttf_pkg::EDGE_W'(i_corner.pos_y) - ttf_pkg::EDGE_W'(r_c0.pos_y);
        o_tri.e2z = ttf_pkg::EDGE_W'(i_corner.pos_z) - ttf_pkg::EDGE_W'(r_c0.pos_z);
        o_tri.du1 = ttf_pkg::DUV_W'(r_c1.tex_u) - ttf_pkg::DUV_W'(r_c0.tex_u);
        o_tri.dv1 = ttf_pkg::DUV_W'(r_c1.tex_v) - ttf_pkg::DUV_W'(r_c0.tex_v);
        o_tri.du2 = ttf_pkg::DUV_W'(i_corner.tex_u) - ttf_pkg::DUV_W'(r_c0.tex_u);
        o_tri.dv2 = ttf_pkg::DUV_W'(i_corner.tex_v) - ttf_pkg::DUV_W'(r_c0.tex_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (w_accept) begin
            unique case (r_count)
                2'd1: begin
                    r_c1    <= i_corner;
                    r_count <= 2'd2;
                end
                2'd2: begin
                    r_count <= 2'd0;
                end
                default: begin
                    r_c0    <= i_corner;
                    r_count <= 2'd1;
                end
            endcase
        end
    end

endmodule

/* src/ttf_queue.sv */
// Short triangle queue between the front and back parts.
`include "triangle_tangent_frame_unit_defines.svh"

module ttf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttf_pkg::t_tri i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ttf_pkg::t_tri o_data
);

    localparam int CNT_W = ttf_pkg::QUEUE_PTR_W + 1;

    ttf_pkg::t_tri                   r_mem [ttf_pkg::QUEUE_DEPTH];
    logic [ttf_pkg::QUEUE_PTR_W-1:0] r_wp;
    logic [ttf_pkg::QUEUE_PTR_W-1:0] r_rp;
    logic [CNT_W-1:0]                r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_count == CNT_W'(ttf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == ttf_pkg::QUEUE_PTR_W'(ttf_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == ttf_pkg::QUEUE_PTR_W'(ttf_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TTF_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(ttf_pkg::QUEUE_DEPTH))
    `TTF_ASSERT_NXT(a_push_grows, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `TTF_ASSERT_NXT(a_pop_shrinks, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

/* src/ttf_back.sv */
// Back part: cross products, normalization, square root and division per triangle.
`include "triangle_tangent_frame_unit_defines.svh"

module ttf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tri_valid,
    input  ttf_pkg::t_tri    i_tri,
    output logic             o_tri_pop,
    output logic             o_res_valid,
    output ttf_pkg::t_result o_res,
    input  logic             i_res_pop
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_LOAD = 9'b000000100,
        S_NORM = 9'b000001000,
        S_SQR  = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_DSET = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_bstate;

    t_bstate                               r_state;
    ttf_pkg::t_tri                         r_tri;
    logic [3:0]                            r_k;
    logic                                  r_pv;
    logic [3:0]                            r_pk;
    logic signed [ttf_pkg::PROD_W-1:0]     r_prod;
    logic signed [ttf_pkg::ACC_W-1:0]      r_acc [ttf_pkg::NUM_TERMS];
    logic                                  r_vsel;
    logic [ttf_pkg::ACC_W-1:0]             r_m [3];
    logic                                  r_neg [3];
    logic [ttf_pkg::SQ_W-1:0]              r_sum;
    logic [ttf_pkg::SQ_W-1:0]              r_a;
    logic [ttf_pkg::SQ_W-1:0]              r_r;
    logic [ttf_pkg::BIT_W-1:0]             r_bit;
    logic [ttf_pkg::REM_W-1:0]             r_rem;
    logic [ttf_pkg::REM_W-1:0]             r_dsr;
    logic [ttf_pkg::Q_W-1:0]               r_q;
    logic [3:0]                            r_it;
    logic signed [ttf_pkg::OUT_W-1:0]      r_res [6];
    logic                                  r_degen;
    ttf_pkg::t_result                      r_out;
    logic                                  r_out_valid;

    logic signed [ttf_pkg::OPA_W-1:0]      w_op_a;
    logic signed [ttf_pkg::OPA_W-1:0]      w_op_b;
    logic signed [ttf_pkg::PROD_W-1:0]     w_prod;
    logic signed [ttf_pkg::ACC_W-1:0]      w_src [3];
    logic [ttf_pkg::ACC_W-1:0]             w_src_mag [3];
    logic [ttf_pkg::ACC_W-1:0]             w_src_or;
    logic [ttf_pkg::ACC_W-1:0]             w_mor;
    logic [ttf_pkg::ACC_W-1:0]             w_msel;
    logic [ttf_pkg::SQ_W:0]                w_rb;
    logic [ttf_pkg::REM_W:0]               w_trial;
    logic [ttf_pkg::Q_W-1:0]               w_qn;
    logic signed [ttf_pkg::OUT_W-1:0]      w_qs;
    logic [2:0]                            w_ridx;
    logic [ttf_pkg::LEN_W-1:0]             w_len;

    assign o_tri_pop   = (r_state == S_IDLE) && i_tri_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_len       = r_r[ttf_pkg::LEN_W-1:0];

    // The one multiplier serves the cross products and the squared magnitudes.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        if (r_state == S_MUL) begin
            unique case (r_k[3:1])
                3'd0: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.du2 : r_tri.du1);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.dv1 : r_tri.dv2);
                end
                3'd1: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.dv1 : r_tri.dv2);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e2x : r_tri.e1x);
                end
                3'd2: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.dv1 : r_tri.dv2);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e2y : r_tri.e1y);
                end
                3'd3: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.dv1 : r_tri.dv2);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e2z : r_tri.e1z);
                end
                3'd4: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.du2 : r_tri.du1);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e1x : r_tri.e2x);
                end
                3'd5: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.du2 : r_tri.du1);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e1y : r_tri.e2y);
                end
                3'd6: begin
                    w_op_a = ttf_pkg::OPA_W'(r_k[0] ? r_tri.du2 : r_tri.du1);
                    w_op_b = ttf_pkg::OPA_W'(r_k[0] ? r_tri.e1z : r_tri.e2z);
                end
                default: begin
                    w_op_a = '0;
                    w_op_b = '0;
                end
            endcase
        end else begin
            w_op_a = $signed({1'b0, w_msel[ttf_pkg::NORM_BITS-1:0]});
            w_op_b = $signed({1'b0, w_msel[ttf_pkg::NORM_BITS-1:0]});
        end
    end

    assign w_prod = w_op_a * w_op_b;

    always_comb begin
        unique case (r_k[1:0])
            2'd1:    w_msel = r_m[1];
            2'd2:    w_msel = r_m[2];
            default: w_msel = r_m[0];
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_src[i]     = r_vsel ? r_acc[4 + i] : r_acc[1 + i];
            w_src_mag[i] = w_src[i][ttf_pkg::ACC_W-1] ? ttf_pkg::ACC_W'(-w_src[i])
                                                      : ttf_pkg::ACC_W'(w_src[i]);
        end
    end

    assign w_src_or = w_src_mag[0] | w_src_mag[1] | w_src_mag[2];
    assign w_mor    = r_m[0] | r_m[1] | r_m[2];
    assign w_rb     = {1'b0, r_r} + {2'b00, r_bit};
    assign w_trial  = {1'b0, r_rem} - {1'b0, r_dsr};
    assign w_qn     = {r_q[ttf_pkg::Q_W-2:0], ~w_trial[ttf_pkg::REM_W]};
    assign w_ridx   = r_vsel ? 3'(r_k[1:0]) + 3'd3 : 3'(r_k[1:0]);

    always_comb begin
        unique case (r_k[1:0])
            2'd1:    w_qs = r_neg[1] ? -$signed({1'b0, w_qn}) : $signed({1'b0, w_qn});
            2'd2:    w_qs = r_neg[2] ? -$signed({1'b0, w_qn}) : $signed({1'b0, w_qn});
            default: w_qs = r_neg[0] ? -$signed({1'b0, w_qn}) : $signed({1'b0, w_qn});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            r_pv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_tri   <= i_tri;
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_k != 4'(ttf_pkg::NUM_PRODUCTS)) begin
                        r_prod <= w_prod;
                        r_pk   <= r_k;
                        r_pv   <= 1'b1;
                        r_k    <= r_k + 1'b1;
                    end
                    // Even products open a term, odd products are subtracted from it.
                    for (int j = 0; j < ttf_pkg::NUM_TERMS; j++) begin
                        if (r_pv && (r_pk[3:1] == 3'(j))) begin
                            r_acc[j] <= r_pk[0] ? r_acc[j] - ttf_pkg::ACC_W'(r_prod)
                                                : ttf_pkg::ACC_W'(r_prod);
                        end
                    end
                    if ((r_k == 4'(ttf_pkg::NUM_PRODUCTS)) && !r_pv) begin
                        r_vsel  <= 1'b0;
                        if (r_acc[0] == '0) begin
                            r_degen <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_degen <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= w_src_mag[i];
                        r_neg[i] <= w_src[i][ttf_pkg::ACC_W-1] ^ r_acc[0][ttf_pkg::ACC_W-1];
                    end
                    if (w_src_or == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // Move the largest magnitude to exactly NORM_BITS significant bits.
                    priority if (|w_mor[ttf_pkg::ACC_W-1:ttf_pkg::NORM_BITS+3]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 4;
                    end else if (|w_mor[ttf_pkg::ACC_W-1:ttf_pkg::NORM_BITS]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!(|w_mor[ttf_pkg::NORM_BITS-1:ttf_pkg::NORM_BITS-4])) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 4;
                    end else if (!w_mor[ttf_pkg::NORM_BITS-1]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (r_k != 4'd3) begin
                        r_prod <= w_prod;
                        r_pv   <= 1'b1;
                        r_k    <= r_k + 1'b1;
                    end
                    if (r_pv) begin
                        r_sum <= r_sum + ttf_pkg::SQ_W'($unsigned(r_prod));
                    end
                    if ((r_k == 4'd3) && !r_pv) begin
                        r_a     <= r_sum;
                        r_r     <= '0;
                        r_bit   <= ttf_pkg::BIT_W'(1) << (ttf_pkg::BIT_W - 1);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ({1'b0, r_a} >= w_rb) begin
                        r_a <= r_a - w_rb[ttf_pkg::SQ_W-1:0];
                        r_r <= (r_r >> 1) + ttf_pkg::SQ_W'(r_bit);
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == ttf_pkg::BIT_W'(1)) begin
                        r_k     <= '0;
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    if (r_k == 4'd3) begin
                        if (!r_vsel) begin
                            r_vsel  <= 1'b1;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        // Rounded quotient: (m * 2^14 + len / 2) / len.
                        r_rem   <= (ttf_pkg::REM_W'(w_msel[ttf_pkg::NORM_BITS-1:0])
                                    << ttf_pkg::FRAC_BITS)
                                   + ttf_pkg::REM_W'(w_len >> 1);
                        r_dsr   <= ttf_pkg::REM_W'(w_len) << ttf_pkg::FRAC_BITS;
                        r_q     <= '0;
                        r_it    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_trial[ttf_pkg::REM_W]) begin
                        r_rem <= w_trial[ttf_pkg::REM_W-1:0];
                    end
                    r_q   <= w_qn;
                    r_dsr <= r_dsr >> 1;
                    r_it  <= r_it + 1'b1;
                    if (r_it == 4'(ttf_pkg::Q_W - 1)) begin
                        r_res[w_ridx] <= w_qs;
                        r_k           <= r_k + 1'b1;
                        r_state       <= S_DSET;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_res_pop) begin
                        r_out.tangent_x   <= r_degen ? '0 : r_res[0];
                        r_out.tangent_y   <= r_degen ? '0 : r_res[1];
                        r_out.tangent_z   <= r_degen ? '0 : r_res[2];
                        r_out.bitangent_x <= r_degen ? '0 : r_res[3];
                        r_out.bitangent_y <= r_degen ? '0 : r_res[4];
                        r_out.bitangent_z <= r_degen ? '0 : r_res[5];
                        r_out.degenerate  <= r_degen;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TTF_ASSERT_IMP(a_degen_zero, r_out_valid && r_out.degenerate, r_out.tangent_x == '0 && r_out.tangent_y == '0 && r_out.tangent_z == '0 && r_out.bitangent_x == '0 && r_out.bitangent_y == '0 && r_out.bitangent_z == '0)
    `TTF_ASSERT_IMP(a_len_range, r_state == S_DIV, (r_r[ttf_pkg::LEN_W-1] || r_r[ttf_pkg::LEN_W-2]) && r_r[ttf_pkg::SQ_W-1:ttf_pkg::LEN_W] == '0)
    `TTF_ASSERT_IMP(a_unit_range, r_out_valid && !r_out.degenerate, r_out.tangent_x <= ttf_pkg::UNIT_Q14 && r_out.tangent_x >= -ttf_pkg::UNIT_Q14 && r_out.bitangent_x <= ttf_pkg::UNIT_Q14 && r_out.bitangent_x >= -ttf_pkg::UNIT_Q14)
    `TTF_ASSERT_NXT(a_pop_drains, i_res_pop && r_out_valid && r_state != S_DONE, !r_out_valid)

endmodule

/* src/triangle_tangent_frame_unit.sv */
// Top level of the per-triangle tangent and bitangent unit.
// Corners are taken one per cycle; only a triangle's closing corner waits for queue room.
// With the back part idle, a result follows the closing corner after the cross products, then per
// vector the load and normalizing shifts, squares, square root and rounding division; a zero
// determinant goes from the cross products straight to the result. The back part takes a new
// triangle only once its result is registered; the queue holds up to two triangles meanwhile.
// Synchronous active-low reset empties the corner count, queue and result register.
module triangle_tangent_frame_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [15:0] i_tex_u,
    input  logic signed [15:0] i_tex_v,
    output logic        empty,
    input  logic        pop,
    output logic signed [15:0] o_tangent_x,
    output logic signed [15:0] o_tangent_y,
    output logic signed [15:0] o_tangent_z,
    output logic signed [15:0] o_bitangent_x,
    output logic signed [15:0] o_bitangent_y,
    output logic signed [15:0] o_bitangent_z,
    output logic        o_degenerate
);

    ttf_pkg::t_corner w_corner;
    ttf_pkg::t_tri    w_front_tri;
    ttf_pkg::t_tri    w_queue_tri;
    ttf_pkg::t_result w_res;
    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_empty;
    logic             w_q_pop;
    logic             w_res_valid;

    assign w_corner.pos_x = i_pos_x;
    assign w_corner.pos_y = i_pos_y;
    assign w_corner.pos_z = i_pos_z;
    assign w_corner.tex_u = i_tex_u;
    assign w_corner.tex_v = i_tex_v;

    ttf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_corner (w_corner),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_tri    (w_front_tri)
    );

    ttf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_tri),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_queue_tri)
    );

    ttf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri_valid (!w_q_empty),
        .i_tri       (w_queue_tri),
        .o_tri_pop   (w_q_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty         = !w_res_valid;
    assign o_tangent_x   = w_res.tangent_x;
    assign o_tangent_y   = w_res.tangent_y;
    assign o_tangent_z   = w_res.tangent_z;
    assign o_bitangent_x = w_res.bitangent_x;
    assign o_bitangent_y = w_res.bitangent_y;
    assign o_bitangent_z = w_res.bitangent_z;
    assign o_degenerate  = w_res.degenerate;

endmodule
